/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the box smoothing block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// The expression holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, ck, rn, expr) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (expr)) \
    else $error("assertion failed");

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, ck, rn, expr)
`define ASSERT_IMPLIES(lbl, ck, rn, ante, cons)
`define ASSERT_NEXT(lbl, ck, rn, ante, cons)

`endif

`endif

/* rtl/core/rbs_pkg.sv */
// ----------------------------------------------------------------------------
// rbs_pkg
// Types, constants and the channel divider of the RGB565 box smoothing block.
// ----------------------------------------------------------------------------
package rbs_pkg;

  // Default geometry and queue sizing.
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int Q_DEPTH_DEF   = 4;

  // Fixed field widths.
  localparam int PIX_W   = 16;
  localparam int CFG_W   = 11;
  localparam int ROW_W   = 12;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Register reset values.
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd1024;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd1024;

  // Register index, taken from paddr[2].
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  // Fixed-point reciprocals, 16 fraction bits, rounded up.
  localparam logic [13:0] RECIP_NINE = 14'd7282;
  localparam logic [13:0] RECIP_SIX  = 14'd10923;

  // Number of neighbors inside the frame.
  typedef enum logic [1:0] {
    CNT_NINE,
    CNT_SIX,
    CNT_FOUR
  } rbs_cnt_t;

  // One window snapshot with its edge classification.
  typedef struct packed {
    logic [8:0][PIX_W-1:0] pix;
    logic                  top_ex;
    logic                  bot_ex;
    logic                  left_ex;
    logic                  right_ex;
    logic                  last;
  } rbs_win_t;

  // Floor of a channel sum divided by the neighbor count.
  function automatic logic [5:0] div_cnt(input logic [9:0] s, input rbs_cnt_t c);
    logic [23:0] prod;
    logic [5:0]  q;
    prod = '0;
    q    = '0;
    case (c)
      CNT_NINE: begin
        prod = {14'd0, s} * {10'd0, RECIP_NINE};
        q    = prod[21:16];
      end
      CNT_SIX: begin
        prod = {14'd0, s} * {10'd0, RECIP_SIX};
        q    = prod[21:16];
      end
      CNT_FOUR: begin
        q = s[7:2];
      end
      default: begin
        q = '0;
      end
    endcase
    return q;
  endfunction

endpackage

/* rtl/core/rbs_stream_if.sv */
// ----------------------------------------------------------------------------
// rbs_in_if / rbs_out_if
// Valid/ready channels for pixel items and smoothed results.
// ----------------------------------------------------------------------------
interface rbs_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [15:0] pixel_in;

  modport source (output valid, output mode, output pixel_in, input ready);
  modport sink (input valid, input mode, input pixel_in, output ready);
endinterface

interface rbs_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel_out;
  logic        frame_last;

  modport source (output valid, output pixel_out, output frame_last, input ready);
  modport sink (input valid, input pixel_out, input frame_last, output ready);
endinterface

/* rtl/core/rbs_fifo.sv */
// ----------------------------------------------------------------------------
// rbs_fifo
// Short queue of window snapshots between the front and the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rbs_fifo
  import rbs_pkg::*;
#(
  parameter int DEPTH = Q_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push_i,
  input  rbs_win_t                   push_data_i,
  input  logic                       pop_i,
  output rbs_win_t                   head_o,
  output logic                       nempty_o,
  output logic [$clog2(DEPTH+1)-1:0] level_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);

  rbs_win_t        ent_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [LW-1:0]   count_r, count_nxt;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_nxt = count_r + 1'b1;
    end else if (pop_i && !push_i) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push_i) begin
      ent_r[wr_ptr_r] <= push_data_i;
    end
  end

  assign head_o   = ent_r[rd_ptr_r];
  assign nempty_o = (count_r != '0);
  assign level_o  = count_r;

  // The front reserves room before it accepts, so the queue never overflows.
  `ASSERT_IMPLIES(a_no_overflow, clk, rst_n, push_i && !pop_i, count_r < LW'(DEPTH))
  // The back pops only entries that are present.
  `ASSERT_IMPLIES(a_no_underflow, clk, rst_n, pop_i, count_r != '0)

endmodule

/* rtl/core/rbs_front.sv */
// ----------------------------------------------------------------------------
// rbs_front
// Accepts pixel items, tracks frame positions, runs the two line stores and
// the 3x3 window, and queues one classified window snapshot per result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rbs_front
  import rbs_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int QDEPTH    = Q_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  rbs_in_if.sink                      in_pix,
  input  logic [$clog2(MAX_WIDTH):0]  used_w_i,
  input  logic [CFG_W-1:0]            used_h_i,
  input  logic                        restart_i,
  input  logic [$clog2(QDEPTH+1)-1:0] q_level_i,
  output logic                        push_o,
  output rbs_win_t                    win_o
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int LW = $clog2(QDEPTH + 1);

  // Line stores: mid holds the previous row, top the one before it.
  logic [PIX_W-1:0] mid_mem [MAX_WIDTH];
  logic [PIX_W-1:0] top_mem [MAX_WIDTH];
  logic [PIX_W-1:0] mid_rd_r, top_rd_r;

  // Input and output positions.
  logic [ROW_W-1:0] in_row_r, in_row_nxt;
  logic [CW-1:0]    in_col_r, in_col_nxt;
  logic [CFG_W-1:0] out_row_r, out_row_nxt;
  logic [CW-1:0]    out_col_r, out_col_nxt;

  // Stage holding an accepted item while the line stores are read.
  logic             f1_valid_r;
  logic [CW-1:0]    f1_col_r;
  logic [PIX_W-1:0] f1_px_r;
  logic             f1_emit_r;
  logic             f1_last_r;
  logic             f1_top_ex_r, f1_bot_ex_r, f1_left_ex_r, f1_right_ex_r;

  logic [8:0][PIX_W-1:0] window_r, window_nxt, shifted;

  logic             acc, skip, go, emit, last;
  logic             top_ex, bot_ex, left_ex, right_ex;
  logic [PIX_W-1:0] px;
  logic [CW:0]      in_col_inc;
  logic [CW:0]      w_last;
  logic [CFG_W-1:0] h_last;

  // Room is reserved for the item in flight and the one being accepted.
  assign in_pix.ready = (({1'b0, q_level_i} + (LW + 1)'(f1_valid_r)) < (LW + 1)'(QDEPTH));

  assign acc  = in_pix.valid && in_pix.ready;
  assign skip = in_pix.mode && (in_row_r == '0) && (in_col_r == '0);
  assign go   = acc && !skip;

  // Flush ticks and pixels past the frame enter as zero.
  assign px = (in_pix.mode || (in_row_r >= ROW_W'(used_h_i))) ? '0 : in_pix.pixel_in;

  assign emit = (in_row_r >= ROW_W'(2)) || ((in_row_r == ROW_W'(1)) && (in_col_r != '0));

  // Classification of the output position.
  assign w_last   = used_w_i - 1'b1;
  assign h_last   = used_h_i - 1'b1;
  assign top_ex   = (out_row_r == '0);
  assign bot_ex   = (out_row_r == h_last);
  assign left_ex  = (out_col_r == '0);
  assign right_ex = ({1'b0, out_col_r} == w_last);
  assign last     = bot_ex && right_ex;

  assign in_col_inc = {1'b0, in_col_r} + 1'b1;

  // Position counters.
  always_comb begin
    in_row_nxt  = in_row_r;
    in_col_nxt  = in_col_r;
    out_row_nxt = out_row_r;
    out_col_nxt = out_col_r;
    if (restart_i || (go && emit && last)) begin
      in_row_nxt  = '0;
      in_col_nxt  = '0;
      out_row_nxt = '0;
      out_col_nxt = '0;
    end else if (go) begin
      if (in_col_inc == used_w_i) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + 1'b1;
      end else begin
        in_col_nxt = in_col_inc[CW-1:0];
      end
      if (emit) begin
        if (right_ex) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + 1'b1;
        end else begin
          out_col_nxt = out_col_r + 1'b1;
        end
      end
    end
  end

  // Window shift with the fresh column from the line stores.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      shifted[r*3]     = window_r[r*3+1];
      shifted[r*3 + 1] = window_r[r*3+2];
    end
    shifted[2] = top_rd_r;
    shifted[5] = mid_rd_r;
    shifted[8] = f1_px_r;
  end

  always_comb begin
    window_nxt = window_r;
    if (restart_i) begin
      window_nxt = '0;
    end else if (f1_valid_r) begin
      window_nxt = (f1_emit_r && f1_last_r) ? '0 : shifted;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r   <= '0;
      in_col_r   <= '0;
      out_row_r  <= '0;
      out_col_r  <= '0;
      f1_valid_r <= 1'b0;
      window_r   <= '0;
    end else begin
      in_row_r   <= in_row_nxt;
      in_col_r   <= in_col_nxt;
      out_row_r  <= out_row_nxt;
      out_col_r  <= out_col_nxt;
      f1_valid_r <= go;
      window_r   <= window_nxt;
    end
  end

  // Stage payload.
  always_ff @(posedge clk) begin
    if (go) begin
      f1_col_r      <= in_col_r;
      f1_px_r       <= px;
      f1_emit_r     <= emit;
      f1_last_r     <= last;
      f1_top_ex_r   <= top_ex;
      f1_bot_ex_r   <= bot_ex;
      f1_left_ex_r  <= left_ex;
      f1_right_ex_r <= right_ex;
    end
  end

  // Line stores: read at the current column, written in the next cycle from the f1 stage.
  always_ff @(posedge clk) begin
    mid_rd_r <= mid_mem[in_col_r];
    top_rd_r <= top_mem[in_col_r];
    if (f1_valid_r) begin
      top_mem[f1_col_r] <= mid_rd_r;
      mid_mem[f1_col_r] <= f1_px_r;
    end
  end

  // Queue a snapshot for every position that yields a result.
  assign push_o         = f1_valid_r && f1_emit_r;
  assign win_o.pix      = shifted;
  assign win_o.top_ex   = f1_top_ex_r;
  assign win_o.bot_ex   = f1_bot_ex_r;
  assign win_o.left_ex  = f1_left_ex_r;
  assign win_o.right_ex = f1_right_ex_r;
  assign win_o.last     = f1_last_r;

  // Accepting never happens without a free queue slot.
  `ASSERT_IMPLIES(a_credit, clk, rst_n, acc, q_level_i < LW'(QDEPTH))
  // The frame's last position returns the input position to the origin.
  `ASSERT_NEXT(a_pos_clear, clk, rst_n, go && emit && last,
               (in_row_r == '0) && (in_col_r == '0))
  // The window is cleared after the last snapshot of a frame.
  `ASSERT_NEXT(a_win_clear, clk, rst_n, f1_valid_r && f1_emit_r && f1_last_r,
               window_r == '0)

endmodule

/* rtl/core/rbs_back.sv */
// ----------------------------------------------------------------------------
// rbs_back
// Sums the in-frame neighbors of a window snapshot per channel, divides by
// the neighbor count and drives the result through an output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rbs_back
  import rbs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  rbs_win_t  head_i,
  input  logic      nempty_i,
  output logic      pop_o,
  rbs_out_if.source out_pix
);

  logic [4:0] cell_r [9];
  logic [5:0] cell_g [9];
  logic [4:0] cell_b [9];
  logic [6:0] row_r  [3];
  logic [7:0] row_g  [3];
  logic [6:0] row_b  [3];
  logic [8:0] sum_r;
  logic [9:0] sum_g;
  logic [8:0] sum_b;
  rbs_cnt_t   cnt;

  logic       b1_valid_r;
  logic [8:0] b1_sr_r;
  logic [9:0] b1_sg_r;
  logic [8:0] b1_sb_r;
  rbs_cnt_t   b1_cnt_r;
  logic       b1_last_r;

  logic             ob_valid_r;
  logic [PIX_W-1:0] ob_pix_r;
  logic             ob_last_r;

  logic ob_adv, b1_adv;
  logic [5:0] q_r, q_g, q_b;

  // Mask the cells outside the frame and split channels.
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      if (((i / 3 == 0) && head_i.top_ex) || ((i / 3 == 2) && head_i.bot_ex) ||
          ((i % 3 == 0) && head_i.left_ex) || ((i % 3 == 2) && head_i.right_ex)) begin
        cell_r[i] = '0;
        cell_g[i] = '0;
        cell_b[i] = '0;
      end else begin
        cell_r[i] = head_i.pix[i][15:11];
        cell_g[i] = head_i.pix[i][10:5];
        cell_b[i] = head_i.pix[i][4:0];
      end
    end
  end

  // Row sums, then the window sum.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_r[r] = 7'(cell_r[r*3]) + 7'(cell_r[r*3+1]) + 7'(cell_r[r*3+2]);
      row_g[r] = 8'(cell_g[r*3]) + 8'(cell_g[r*3+1]) + 8'(cell_g[r*3+2]);
      row_b[r] = 7'(cell_b[r*3]) + 7'(cell_b[r*3+1]) + 7'(cell_b[r*3+2]);
    end
    sum_r = 9'(row_r[0]) + 9'(row_r[1]) + 9'(row_r[2]);
    sum_g = 10'(row_g[0]) + 10'(row_g[1]) + 10'(row_g[2]);
    sum_b = 9'(row_b[0]) + 9'(row_b[1]) + 9'(row_b[2]);
  end

  // Neighbor count from the edge flags.
  always_comb begin
    if ((head_i.top_ex || head_i.bot_ex) && (head_i.left_ex || head_i.right_ex)) begin
      cnt = CNT_FOUR;
    end else if (head_i.top_ex || head_i.bot_ex || head_i.left_ex || head_i.right_ex) begin
      cnt = CNT_SIX;
    end else begin
      cnt = CNT_NINE;
    end
  end

  // Stage advance: each stage moves when the one after it has room.
  assign ob_adv = !ob_valid_r || out_pix.ready;
  assign b1_adv = !b1_valid_r || ob_adv;
  assign pop_o  = nempty_i && b1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r <= 1'b0;
      ob_valid_r <= 1'b0;
    end else begin
      if (b1_adv) begin
        b1_valid_r <= nempty_i;
      end
      if (ob_adv) begin
        ob_valid_r <= b1_valid_r;
      end
    end
  end

  // Sum stage.
  always_ff @(posedge clk) begin
    if (pop_o) begin
      b1_sr_r   <= sum_r;
      b1_sg_r   <= sum_g;
      b1_sb_r   <= sum_b;
      b1_cnt_r  <= cnt;
      b1_last_r <= head_i.last;
    end
  end

  // Divide and repack into the output register.
  assign q_r = div_cnt({1'b0, b1_sr_r}, b1_cnt_r);
  assign q_g = div_cnt(b1_sg_r, b1_cnt_r);
  assign q_b = div_cnt({1'b0, b1_sb_r}, b1_cnt_r);

  always_ff @(posedge clk) begin
    if (ob_adv && b1_valid_r) begin
      ob_pix_r  <= {q_r[4:0], q_g, q_b[4:0]};
      ob_last_r <= b1_last_r;
    end
  end

  assign out_pix.valid      = ob_valid_r;
  assign out_pix.pixel_out  = ob_pix_r;
  assign out_pix.frame_last = ob_last_r;

  // A sum stage that cannot move keeps its contents.
  `ASSERT_NEXT(a_b1_hold, clk, rst_n, b1_valid_r && !ob_adv,
               b1_valid_r && $stable(b1_sg_r) && $stable(b1_last_r))

endmodule

/* rtl/core/rgb565_box_smooth_3x3.sv */
// ----------------------------------------------------------------------------
// rgb565_box_smooth_3x3
// 3x3 box smoothing of an RGB565 raster stream with edge-aware averaging.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload                         Handshake
// in_pix    in   mode, pixel_in[15:0]            valid/ready
// out_pix   out  pixel_out[15:0], frame_last     valid/ready
// apb       in   paddr[2:0], pwdata/prdata[31:0] psel/penable/pwrite/pready
//
// One pixel item is taken per clock while in_pix.ready is high; the window
// stage and line store port pair set that figure. Results run one row plus
// one pixel behind the input position, via the queue, sum and output stages.
// Reset is synchronous, active low; the line stores are not cleared.
// A stalled output fills the sum and output stages and the four-entry
// snapshot queue, after which in_pix.ready drops.
// ----------------------------------------------------------------------------
module rgb565_box_smooth_3x3
  import rbs_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int QDEPTH    = Q_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  rbs_in_if.sink             in_pix,
  rbs_out_if.source          out_pix,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int UW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam int LW = $clog2(QDEPTH + 1);

  logic [CFG_W-1:0] frame_width_r, frame_width_nxt;
  logic [CFG_W-1:0] frame_height_r, frame_height_nxt;
  logic             wr;
  logic [UW-1:0]    fw_ext, uw_full;
  logic [CW:0]      used_w;
  logic [CFG_W-1:0] used_h;

  logic          push;
  rbs_win_t      push_win;
  logic          pop;
  rbs_win_t      head;
  logic          nempty;
  logic [LW-1:0] q_level;

  // Register writes; any write restarts the stream.
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    if (wr) begin
      case (paddr[2])
        REG_FRAME_WIDTH:  frame_width_nxt  = pwdata[CFG_W-1:0];
        REG_FRAME_HEIGHT: frame_height_nxt = pwdata[CFG_W-1:0];
        default:          frame_width_nxt  = frame_width_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[2])
      REG_FRAME_WIDTH:  prdata = PDATA_W'(frame_width_r);
      REG_FRAME_HEIGHT: prdata = PDATA_W'(frame_height_r);
      default:          prdata = '0;
    endcase
  end

  // Effective geometry: width held to 2..MAX_WIDTH, height at least 2.
  assign fw_ext = UW'(frame_width_r);
  always_comb begin
    if (fw_ext < UW'(2)) begin
      uw_full = UW'(2);
    end else if (fw_ext > UW'(MAX_WIDTH)) begin
      uw_full = UW'(MAX_WIDTH);
    end else begin
      uw_full = fw_ext;
    end
  end
  assign used_w = uw_full[CW:0];
  assign used_h = (frame_height_r < CFG_W'(2)) ? CFG_W'(2) : frame_height_r;

  rbs_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .QDEPTH    (QDEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (in_pix),
    .used_w_i  (used_w),
    .used_h_i  (used_h),
    .restart_i (wr),
    .q_level_i (q_level),
    .push_o    (push),
    .win_o     (push_win)
  );

  rbs_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .push_data_i (push_win),
    .pop_i       (pop),
    .head_o      (head),
    .nempty_o    (nempty),
    .level_o     (q_level)
  );

  rbs_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_i   (head),
    .nempty_i (nempty),
    .pop_o    (pop),
    .out_pix  (out_pix)
  );

endmodule

/* verif/rgb565_box_smooth_3x3_tb.sv */
// ----------------------------------------------------------------------------
// rgb565_box_smooth_3x3_tb
// Self-checking bench for the 3x3 RGB565 box smoother. A short table of
// frames covers the corner, edge and flush cases, then random frames of many
// shapes run with random gaps on both channels and one long output stall.
// Every result is compared with a table value or an in-bench smoothing model.
// ----------------------------------------------------------------------------
module rgb565_box_smooth_3x3_tb;
  import rbs_pkg::*;

  localparam int LINE_LEN     = MAX_WIDTH_DEF;
  localparam int RANDOM_ITEMS = 520;
  localparam int MAX_GAP      = 4;
  localparam int HOLD_AT      = 150;
  localparam int LONG_HOLD    = 120;
  localparam int SETTLE       = 8;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int REPORT_MAX   = 10;

  typedef enum logic {
    MODE_PIXEL = 1'b0,
    MODE_FLUSH = 1'b1
  } item_mode_t;

  typedef enum logic {
    STEP_CFG,
    STEP_ITEM
  } step_kind_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             last;
  } smooth_res_t;

  typedef struct packed {
    step_kind_t       kind;
    logic             reg_sel;
    logic [CFG_W-1:0] value;
    item_mode_t       mode;
    logic [PIX_W-1:0] pixel;
    logic             typed;
    logic [PIX_W-1:0] exp_pixel;
    logic             exp_last;
  } step_t;

  // Directed frames: a 2x2 frame of white written through out-of-range
  // register values, an idle flush, then a 3x3 frame with a flush inside it
  // and a pixel arriving after its end.
  localparam step_t DIRECTED_PLAN [25] = '{
    '{STEP_CFG,  REG_FRAME_WIDTH,  11'd0, MODE_PIXEL, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{STEP_CFG,  REG_FRAME_HEIGHT, 11'd1, MODE_PIXEL, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{STEP_ITEM, 1'b0, 11'd0, MODE_PIXEL, 16'hFFFF, 1'b0, 16'h0000, 1'b0},
    '{STEP_ITEM, 1'b0, 11'd0, MODE_PIXEL, 16'hFFFF, 1'b0, 16'h0000, 1'b0},
    '{STEP_ITEM, 1'b0, 11'd0, MODE_PIXEL, 16'hFFFF, 1'b0, 16'h0000, 1'b0},
    '{STEP_ITEM, 1'b0, 11'd0, MODE_PIXEL, 16'hFFFF, 1'b1, 16'hFFFF, 1'b0},
    '{STEP_ITEM, 1'b0, 11'd0, MODE_FLUSH, 16'h0000, 1'b1, 16'hFFFF, 1'b0},
    '{STEP_ITEM, 1'b0, 11'd0, MODE_FLUSH, 16'h0000, 1'b1, 16'hFFFF, 1'b0},
    '{STEP_ITEM, 1'b0, 11'd0, MODE_FLUSH, 16'h0000, 1'b1, 16'hFFFF, 1'b1},
    '{STEP_ITEM, 1'b0, 11'd0, MODE_FLUSH, 16'hABCD, 1'b0, 16'h0000, 1'b0},
    '{STEP_CFG,  REG_FRAME_WIDTH,  11'd3, MODE_PIXEL, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{STEP_CFG,  REG_FRAME_HEIGHT, 11'd3, MODE_PIXEL, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{STEP_ITEM, 1'b0, 11'd0, MODE_PIXEL, 16'hFFFF, 1'b0, 16'h0000, 1'b0},
    '{STEP_ITEM, 1'b0, 11'd0, MODE_PIXEL, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{STEP_ITEM, 1'b0, 11'd0, MODE_PIXEL, 16'hF800, 1'b0, 16'h0000, 1'b0},
    '{STEP_ITEM, 1'b0, 11'd0, MODE_PIXEL, 16'h07E0, 1'b0, 16'h0000, 1'b0},
    '{STEP_ITEM, 1'b0, 11'd0, MODE_FLUSH, 16'hFFFF, 1'b0, 16'h0000, 1'b0},
    '{STEP_ITEM, 1'b0, 11'd0, MODE_PIXEL, 16'h001F, 1'b0, 16'h0000, 1'b0},
    '{STEP_ITEM, 1'b0, 11'd0, MODE_PIXEL, 16'hFFFF, 1'b0, 16'h0000, 1'b0},
    '{STEP_ITEM, 1'b0, 11'd0, MODE_PIXEL, 16'h5AA5, 1'b0, 16'h0000, 1'b0},
    '{STEP_ITEM, 1'b0, 11'd0, MODE_PIXEL, 16'h8410, 1'b0, 16'h0000, 1'b0},
    '{STEP_ITEM, 1'b0, 11'd0, MODE_PIXEL, 16'hFFFF, 1'b0, 16'h0000, 1'b0},
    '{STEP_ITEM, 1'b0, 11'd0, MODE_FLUSH, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{STEP_ITEM, 1'b0, 11'd0, MODE_FLUSH, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{STEP_ITEM, 1'b0, 11'd0, MODE_FLUSH, 16'h0000, 1'b0, 16'h0000, 1'b0}
  };

  logic               clk;
  logic               rst_n;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  rbs_in_if  in_pix ();
  rbs_out_if out_pix ();

  rgb565_box_smooth_3x3 dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (in_pix),
    .out_pix (out_pix),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Smoothing model state.
  logic [CFG_W-1:0] cfg_width;
  logic [CFG_W-1:0] cfg_height;
  logic [PIX_W-1:0] line_mem [2*LINE_LEN];
  logic [PIX_W-1:0] win [9];
  int               pos_row;
  int               pos_col;
  int               out_pos;

  smooth_res_t      smoothed_q [$];
  int               fail_count;
  int               frame_items;
  int               send_count;
  bit               send_calm;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #400_000;
    $display("rgb565_box_smooth_3x3_tb: errors");
    $finish;
  end

  function automatic int used_width();
    if (cfg_width < 2) return 2;
    if (cfg_width > LINE_LEN) return LINE_LEN;
    return int'(cfg_width);
  endfunction

  function automatic int used_height();
    return (cfg_height < 2) ? 2 : int'(cfg_height);
  endfunction

  function automatic void restart_stream();
    pos_row = 0;
    pos_col = 0;
    out_pos = 0;
    foreach (win[i]) win[i] = '0;
  endfunction

  // Advance the model by one accepted item; returns 1 when a pixel comes out.
  function automatic bit smooth_step(input item_mode_t m, input logic [PIX_W-1:0] p,
                                     output smooth_res_t res);
    int          w;
    int          h;
    int          col;
    int          orow;
    int          ocol;
    int          cnt;
    int          sr;
    int          sg;
    int          sb;
    logic [15:0] px;
    logic [15:0] top;
    logic [15:0] mid;
    logic [15:0] v;
    logic [4:0]  qr;
    logic [5:0]  qg;
    logic [4:0]  qb;
    bit          emit;
    bit          last;
    w   = used_width();
    h   = used_height();
    res = '0;
    // A flush with no frame in progress is dropped.
    if (m == MODE_FLUSH && pos_row == 0 && pos_col == 0) return 1'b0;
    // Flushes and anything past the last frame row shift in black.
    px  = (m == MODE_FLUSH || pos_row >= h) ? 16'h0000 : p;
    col = (pos_col >= LINE_LEN) ? 0 : pos_col;
    top = line_mem[LINE_LEN + col];
    mid = line_mem[col];
    line_mem[LINE_LEN + col] = mid;
    line_mem[col] = px;
    for (int r = 0; r < 3; r++) begin
      win[r*3]     = win[r*3 + 1];
      win[r*3 + 1] = win[r*3 + 2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = px;
    emit = (pos_row >= 2) || (pos_row == 1 && pos_col >= 1);
    pos_col++;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
    end
    if (!emit) return 1'b0;
    // Average the neighbors that fall inside the frame.
    orow = out_pos / w;
    ocol = out_pos % w;
    cnt  = 0;
    sr   = 0;
    sg   = 0;
    sb   = 0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (!(r == 0 && orow == 0) && !(r == 2 && orow + 1 >= h) &&
            !(c == 0 && ocol == 0) && !(c == 2 && ocol + 1 >= w)) begin
          v   = win[r*3 + c];
          sr += int'(v[15:11]);
          sg += int'(v[10:5]);
          sb += int'(v[4:0]);
          cnt++;
        end
      end
    end
    if (cnt == 0) cnt = 1;
    qr = 5'(sr / cnt);
    qg = 6'(sg / cnt);
    qb = 5'(sb / cnt);
    last = (out_pos + 1 >= w * h);
    res.pix  = {qr, qg, qb};
    res.last = last;
    if (last) restart_stream();
    else out_pos++;
    return 1'b1;
  endfunction

  task automatic log_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_MAX) $display("%s", msg);
  endtask

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Offer one item after a random gap and hold it until the transfer.
  task automatic put_pixel(input item_mode_t m, input logic [PIX_W-1:0] p,
                           input bit typed, input smooth_res_t typed_res);
    int          gap;
    smooth_res_t pred;
    bit          emitted;
    if (send_count % 40 == 0) send_calm = ($urandom_range(0, 3) == 0);
    send_count++;
    gap = send_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_pix.valid    <= 1'b1;
    in_pix.mode     <= m;
    in_pix.pixel_in <= p;
    do @(posedge clk); while (in_pix.ready !== 1'b1);
    emitted = smooth_step(m, p, pred);
    if (typed) smoothed_q.push_back(typed_res);
    else if (emitted) smoothed_q.push_back(pred);
  endtask

  // Let every pending result drain, then give the pipeline time to settle.
  task automatic wait_idle();
    int n;
    n = 0;
    in_pix.valid <= 1'b0;
    while (smoothed_q.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE) @(posedge clk);
  endtask

  // Register write over the APB port; the model restarts with it.
  task automatic write_reg(input logic sel, input logic [CFG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= {{(PDATA_W-CFG_W){1'b0}}, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (sel == REG_FRAME_WIDTH) cfg_width = value;
    else cfg_height = value;
    restart_stream();
    @(posedge clk);
  endtask

  // One whole frame with random content, then its flush tail. The first
  // pixel is always a real pixel so the frame keeps its length.
  task automatic stream_frame();
    int         w;
    int         h;
    item_mode_t m;
    w = used_width();
    h = used_height();
    for (int k = 0; k < w * h; k++) begin
      m = (k != 0 && $urandom_range(0, 29) == 0) ? MODE_FLUSH : MODE_PIXEL;
      put_pixel(m, rand_pixel(), 1'b0, '0);
      frame_items++;
    end
    for (int k = 0; k <= w; k++) begin
      m = ($urandom_range(0, 3) == 0) ? MODE_PIXEL : MODE_FLUSH;
      put_pixel(m, rand_pixel(), 1'b0, '0);
      frame_items++;
    end
    // Stray flushes between frames are ignored by the block.
    repeat ($urandom_range(0, 2)) put_pixel(MODE_FLUSH, rand_pixel(), 1'b0, '0);
  endtask

  // Stimulus: directed table, then random frames.
  initial begin : stimulus
    step_t       row;
    smooth_res_t typed_res;
    rst_n           <= 1'b0;
    in_pix.valid    <= 1'b0;
    in_pix.mode     <= MODE_PIXEL;
    in_pix.pixel_in <= '0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    fail_count  = 0;
    frame_items = 0;
    send_count  = 0;
    send_calm   = 1'b0;
    cfg_width   = FRAME_WIDTH_RST;
    cfg_height  = FRAME_HEIGHT_RST;
    foreach (line_mem[i]) line_mem[i] = '0;
    restart_stream();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED_PLAN[i]) begin
      row = DIRECTED_PLAN[i];
      if (row.kind == STEP_CFG) begin
        wait_idle();
        write_reg(row.reg_sel, row.value);
      end else begin
        typed_res = '{pix: row.exp_pixel, last: row.exp_last};
        put_pixel(row.mode, row.pixel, row.typed, typed_res);
      end
    end

    // Small random frames, sometimes keeping the previous geometry.
    frame_items = 0;
    while (frame_items < RANDOM_ITEMS) begin
      wait_idle();
      if ($urandom_range(0, 1) == 1) begin
        if ($urandom_range(0, 7) == 0) write_reg(REG_FRAME_WIDTH, 11'($urandom_range(10, 40)));
        else write_reg(REG_FRAME_WIDTH, 11'($urandom_range(0, 9)));
      end
      if ($urandom_range(0, 1) == 1) write_reg(REG_FRAME_HEIGHT, 11'($urandom_range(0, 6)));
      stream_frame();
    end

    wait_idle();
    if (smoothed_q.size() != 0)
      log_failure($sformatf("%0d expected results never arrived", smoothed_q.size()));
    if (fail_count == 0) begin
      $display("rgb565_box_smooth_3x3_tb: clean");
    end else begin
      $display("rgb565_box_smooth_3x3_tb: errors");
    end
    $finish;
  end

  // Result side: random stalls, one long hold-off, and the field checks.
  initial begin : result_sink
    int          gap;
    int          taken;
    bit          held;
    bit          calm;
    smooth_res_t want;
    taken = 0;
    held  = 1'b0;
    calm  = 1'b0;
    out_pix.ready <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (taken % 32 == 0) calm = ($urandom_range(0, 3) == 0);
      gap = calm ? 0 : $urandom_range(0, MAX_GAP);
      // Hold the output off long enough for the input to back up.
      if (!held && taken == HOLD_AT) begin
        held = 1'b1;
        gap  = LONG_HOLD;
      end
      if (gap > 0) begin
        out_pix.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_pix.ready <= 1'b1;
      do @(posedge clk); while (out_pix.valid !== 1'b1);
      taken++;
      if (smoothed_q.size() == 0) begin
        log_failure($sformatf("result %0d: unexpected transfer, pixel_out %04h frame_last %b",
                              taken, out_pix.pixel_out, out_pix.frame_last));
      end else begin
        want = smoothed_q.pop_front();
        if (out_pix.pixel_out !== want.pix)
          log_failure($sformatf("result %0d: pixel_out expected %04h, got %04h",
                                taken, want.pix, out_pix.pixel_out));
        if (out_pix.frame_last !== want.last)
          log_failure($sformatf("result %0d: frame_last expected %b, got %b",
                                taken, want.last, out_pix.frame_last));
      end
    end
  end

endmodule
